// File: rtl/sbus_frame_receiver_defines.svh
// ----------------------------------------------------------------------------
// S-BUS frame receiver assertion macros
// Shared property forms used by the checker of the frame receiver.
// ----------------------------------------------------------------------------
`ifndef SBUS_FRAME_RECEIVER_DEFINES_SVH
`define SBUS_FRAME_RECEIVER_DEFINES_SVH

// A signal holds its value in the cycle after a stalled beat.
`define SFR_ASSERT_HOLD(lbl, clk, rst_n, vld, rdy, sig) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        (vld && !rdy) |=> $stable(sig)) else $error("Stalled beat changed.");

// A condition implies a consequence in the same cycle.
`define SFR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |-> (cons)) else $error("Implication failed.");

`endif

// File: rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// S-BUS frame receiver package
// Constants and shared types of the frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

    localparam logic [7:0] START_BYTE = 8'h0F;
    localparam logic [7:0] END_BYTE   = 8'h00;

    localparam int CNT_W     = 5;
    localparam logic [CNT_W-1:0] END_POS  = 5'd24;
    localparam logic [CNT_W-1:0] FLAG_POS = 5'd23;

    localparam int CHAN_BITS  = 11;
    localparam int IDX_W      = 4;
    localparam logic [IDX_W-1:0] LAST_CHAN = 4'd15;
    localparam int FLAG_W     = 4;

    localparam int BANKS      = 2;
    localparam int BANK_W     = $clog2(BANKS);
    localparam int SLOT_W     = 5;
    localparam int RAM_WIDTH  = 8;
    localparam int RAM_DEPTH  = BANKS * (2 ** SLOT_W);
    localparam int RAM_AW     = $clog2(RAM_DEPTH);

    localparam int JOB_DEPTH  = BANKS;

    localparam int ACC_W      = CHAN_BITS + RAM_WIDTH - 1;
    localparam int ACC_CW     = $clog2(ACC_W + 1);

    typedef struct packed {
        logic [BANK_W-1:0] bank;
        logic [FLAG_W-1:0] flags;
    } t_sfr_job;

    typedef struct packed {
        logic              valid;
        logic [BANK_W-1:0] bank;
    } t_sfr_done;

endpackage

`default_nettype wire

// File: rtl/sfr_if.sv
// ----------------------------------------------------------------------------
// S-BUS frame receiver channels
// Valid/ready channels for received bytes and decoded channel results.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfr_chan_if;
    logic        valid;
    logic        ready;
    logic [3:0]  channel_index;
    logic [10:0] channel_value;
    logic        digital_one;
    logic        digital_two;
    logic        frame_lost;
    logic        failsafe_active;
    logic        last;

    modport source (output valid, output channel_index, output channel_value,
                    output digital_one, output digital_two, output frame_lost,
                    output failsafe_active, output last, input ready);
    modport sink (input valid, input channel_index, input channel_value,
                  input digital_one, input digital_two, input frame_lost,
                  input failsafe_active, input last, output ready);
endinterface

`default_nettype wire

// File: rtl/sfr_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// File: rtl/sfr_front.sv
// ----------------------------------------------------------------------------
// S-BUS frame receiver front end
// Hunts for the start byte, stores frame bytes into a free bank and queues
// a decode job when the end byte is good.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    sfr_byte_if.sink                      i_rx,
    output logic                          o_wr_en,
    output logic [sfr_pkg::RAM_AW-1:0]    o_wr_addr,
    output logic [7:0]                    o_wr_data,
    output logic                          o_push,
    output sfr_pkg::t_sfr_job             o_job,
    input  sfr_pkg::t_sfr_done            i_done
);
    import sfr_pkg::*;

    logic [CNT_W-1:0]  r_count, n_count;
    logic [BANK_W-1:0] r_bank, n_bank;
    logic [BANKS-1:0]  r_busy, n_busy;
    logic [FLAG_W-1:0] r_flags, n_flags;
    logic              in_frame;
    logic              accept;

    assign in_frame   = (r_count != '0) && (r_count < END_POS);
    assign i_rx.ready = !(in_frame && r_busy[r_bank]);
    assign accept     = i_rx.valid && i_rx.ready;

    assign o_wr_en   = accept && in_frame;
    assign o_wr_addr = {r_bank, r_count - 5'd1};
    assign o_wr_data = i_rx.rx_byte;
    assign o_push    = accept && (r_count == END_POS) && (i_rx.rx_byte == END_BYTE);
    assign o_job     = '{bank: r_bank, flags: r_flags};

    always_comb begin
        n_count = r_count;
        n_bank  = r_bank;
        n_flags = r_flags;
        n_busy  = r_busy;
        if (i_done.valid) begin
            n_busy[i_done.bank] = 1'b0;
        end
        if (accept) begin
            if (r_count == '0 || r_count > END_POS) begin
                n_count = (i_rx.rx_byte == START_BYTE) ? 5'd1 : 5'd0;
            end else if (r_count < END_POS) begin
                n_count = r_count + 5'd1;
                if (r_count == FLAG_POS) begin
                    n_flags = i_rx.rx_byte[FLAG_W-1:0];
                end
            end else begin
                n_count = '0;
                if (o_push) begin
                    n_busy[r_bank] = 1'b1;
                    n_bank         = r_bank + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_bank  <= '0;
            r_busy  <= '0;
        end else begin
            r_count <= n_count;
            r_bank  <= n_bank;
            r_busy  <= n_busy;
        end
        r_flags <= n_flags;
    end

endmodule

`default_nettype wire

// File: rtl/sfr_job_queue.sv
// ----------------------------------------------------------------------------
// S-BUS frame receiver job queue
// Small FIFO of decode jobs between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_job_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  sfr_pkg::t_sfr_job i_job,
    input  logic              i_pop,
    output logic              o_valid,
    output sfr_pkg::t_sfr_job o_job
);
    import sfr_pkg::*;

    localparam int PTR_W = $clog2(JOB_DEPTH);
    localparam int CNT_QW = $clog2(JOB_DEPTH + 1);

    t_sfr_job          r_mem [JOB_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_QW-1:0] r_fill;
    logic              do_pop;

    assign o_valid = (r_fill != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(JOB_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(JOB_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (!i_push && do_pop) begin
                r_fill <= r_fill - 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

`default_nettype wire

// File: rtl/sfr_back.sv
// ----------------------------------------------------------------------------
// S-BUS frame receiver back end
// Streams the data bytes of a stored frame through a bit accumulator and
// emits one 11-bit channel result at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_job_valid,
    input  sfr_pkg::t_sfr_job          i_job,
    output logic                       o_pop,
    output logic [sfr_pkg::RAM_AW-1:0] o_rd_addr,
    input  logic [7:0]                 i_rd_data,
    output sfr_pkg::t_sfr_done         o_done,
    sfr_chan_if.source                 o_ch
);
    import sfr_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_LOAD  = 2'd1;
    localparam logic [1:0] ST_CHECK = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [BANK_W-1:0]   r_bank, n_bank;
    logic [FLAG_W-1:0]   r_flags, n_flags;
    logic [SLOT_W-1:0]   r_ptr, n_ptr;
    logic [ACC_W-1:0]    r_acc, n_acc;
    logic [ACC_CW-1:0]   r_bits, n_bits;
    logic [IDX_W-1:0]    r_chan, n_chan;

    logic                r_ovalid, n_ovalid;
    logic [IDX_W-1:0]    r_oindex, n_oindex;
    logic [CHAN_BITS-1:0] r_ovalue, n_ovalue;
    logic [FLAG_W-1:0]   r_oflags, n_oflags;
    logic                r_olast, n_olast;
    logic                emit;

    assign o_rd_addr = (r_state == ST_IDLE) ? {i_job.bank, {SLOT_W{1'b0}}} : {r_bank, r_ptr};

    always_comb begin
        n_state  = r_state;
        n_bank   = r_bank;
        n_flags  = r_flags;
        n_ptr    = r_ptr;
        n_acc    = r_acc;
        n_bits   = r_bits;
        n_chan   = r_chan;
        n_ovalid = r_ovalid && !o_ch.ready;
        n_oindex = r_oindex;
        n_ovalue = r_ovalue;
        n_oflags = r_oflags;
        n_olast  = r_olast;
        emit     = 1'b0;
        o_pop    = 1'b0;
        o_done   = '{valid: 1'b0, bank: r_bank};
        case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    n_bank  = i_job.bank;
                    n_flags = i_job.flags;
                    n_ptr   = '0;
                    n_acc   = '0;
                    n_bits  = '0;
                    n_chan  = '0;
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_acc   = r_acc | (ACC_W'(i_rd_data) << r_bits);
                n_bits  = r_bits + ACC_CW'(RAM_WIDTH);
                n_ptr   = r_ptr + 1'b1;
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (r_bits >= ACC_CW'(CHAN_BITS)) begin
                    if (!r_ovalid || o_ch.ready) begin
                        emit     = 1'b1;
                        n_ovalid = 1'b1;
                        n_oindex = r_chan;
                        n_ovalue = r_acc[CHAN_BITS-1:0];
                        n_oflags = r_flags;
                        n_olast  = (r_chan == LAST_CHAN);
                        n_acc    = r_acc >> CHAN_BITS;
                        n_bits   = r_bits - ACC_CW'(CHAN_BITS);
                        n_chan   = r_chan + 1'b1;
                        if (r_chan == LAST_CHAN) begin
                            o_pop        = 1'b1;
                            o_done.valid = 1'b1;
                            n_state      = ST_IDLE;
                        end
                    end
                end else begin
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
        r_bank   <= n_bank;
        r_flags  <= n_flags;
        r_ptr    <= n_ptr;
        r_acc    <= n_acc;
        r_bits   <= n_bits;
        r_chan   <= n_chan;
        if (emit) begin
            r_oindex <= n_oindex;
            r_ovalue <= n_ovalue;
            r_oflags <= n_oflags;
            r_olast  <= n_olast;
        end
    end

    assign o_ch.valid           = r_ovalid;
    assign o_ch.channel_index   = r_oindex;
    assign o_ch.channel_value   = r_ovalue;
    assign o_ch.digital_one     = r_oflags[0];
    assign o_ch.digital_two     = r_oflags[1];
    assign o_ch.frame_lost      = r_oflags[2];
    assign o_ch.failsafe_active = r_oflags[3];
    assign o_ch.last            = r_olast;

endmodule

`default_nettype wire

// File: rtl/sbus_frame_receiver.sv
// Flow: a byte is taken when valid and ready are both high; the first channel beat
// of a good frame passes the job queue, the back end's load and check states and its
// output register after the end byte. Without output stalls the back end spends a
// load and a check step per data byte and a check step per channel beat; two banks
// let the front end take one byte per cycle until both banks wait for decoding.
// Reset: synchronous, active low; the receiver hunts for a start byte after it.
// ----------------------------------------------------------------------------
// S-BUS frame receiver
// Front end, job queue, double-banked frame RAM and channel unpacking back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sbus_frame_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sfr_byte_if.sink    i_rx,
    sfr_chan_if.source  o_ch
);
    import sfr_pkg::*;

    logic              wr_en;
    logic [RAM_AW-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic [RAM_AW-1:0] rd_addr;
    logic [7:0]        rd_data;
    logic              push;
    logic              pop;
    logic              job_valid;
    t_sfr_job          push_job;
    t_sfr_job          head_job;
    t_sfr_done         done;

    sfr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rx      (i_rx),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_push    (push),
        .o_job     (push_job),
        .i_done    (done)
    );

    sfr_job_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_valid (job_valid),
        .o_job   (head_job)
    );

    sfr_ram #(
        .WIDTH (RAM_WIDTH),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    sfr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_done      (done),
        .o_ch        (o_ch)
    );

endmodule

`default_nettype wire

// File: rtl/sfr_checker.sv
// ----------------------------------------------------------------------------
// S-BUS frame receiver checker
// Port-level assertions on the channel result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sbus_frame_receiver_defines.svh"

module sfr_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_ready,
    input  logic [3:0]  i_index,
    input  logic [10:0] i_value,
    input  logic [3:0]  i_flags,
    input  logic        i_last
);
    import sfr_pkg::*;

    logic [19:0] beat;

    assign beat = {i_index, i_value, i_flags, i_last};

    `SFR_ASSERT_HOLD(a_valid_hold, i_clk, i_rst_n, i_valid, i_ready, i_valid)
    `SFR_ASSERT_HOLD(a_beat_hold, i_clk, i_rst_n, i_valid, i_ready, beat)
    `SFR_ASSERT_IMPL(a_last_chan, i_clk, i_rst_n, i_valid, i_last == (i_index == LAST_CHAN))
    `SFR_ASSERT_IMPL(a_quiet_reset, i_clk, i_rst_n, $past(!i_rst_n), !i_valid)

endmodule

bind sbus_frame_receiver sfr_checker u_sfr_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_ch.valid),
    .i_ready (o_ch.ready),
    .i_index (o_ch.channel_index),
    .i_value (o_ch.channel_value),
    .i_flags ({o_ch.failsafe_active, o_ch.frame_lost, o_ch.digital_two, o_ch.digital_one}),
    .i_last  (o_ch.last)
);

`default_nettype wire
